@@ rtl/mbrir_pkg.sv @@
// Shared types, constants and the CRC-16 byte step for the function 04 responder.
// No dependencies; imported by every module in rtl/.
package mbrir_pkg;

    localparam int REG_DEPTH = 256;
    localparam int MAX_READ  = 125;
    localparam int REG_AW    = $clog2(REG_DEPTH);
    localparam int LIMIT_W   = 9;

    localparam logic [7:0]  FRAME_LEN     = 8'd8;
    localparam logic [7:0]  EXC_FUNCTION  = 8'h84;
    localparam logic [7:0]  EXC_BAD_ADDR  = 8'd2;
    localparam logic [7:0]  EXC_BAD_VALUE = 8'd3;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic CFG_SLAVE_ADDRESS    = 1'b0;
    localparam logic CFG_REGISTERS_IN_USE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  load_index;
        logic [15:0] load_value;
        logic [7:0]  frame_address;
        logic [7:0]  function_code;
        logic [15:0] first_register;
        logic [15:0] register_count;
        logic [7:0]  frame_length;
    } req_item_t;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  bytes_valid;
        logic        is_exception;
        logic        last;
    } rsp_item_t;

    // one byte of the outgoing frame, sequencer to packer
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       exc;
    } beat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDR0,
        S_HDR1,
        S_HDR2,
        S_RD,
        S_VHI,
        S_VLO,
        S_CRCLO,
        S_CRCHI
    } state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/mbrir_store.sv @@
// Input register store: one write port, one registered read port.
// Per-entry valid bits make never-loaded entries read as zero. Uses mbrir_pkg.
module mbrir_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [mbrir_pkg::REG_AW-1:0] wr_addr,
    input  logic [15:0]                wr_data,
    input  logic                       rd_en,
    input  logic [mbrir_pkg::REG_AW-1:0] rd_addr,
    output logic [15:0]                rd_data
);
    import mbrir_pkg::*;

    logic [15:0]          mem [REG_DEPTH];
    logic [REG_DEPTH-1:0] vld_reg;
    logic [15:0]          rd_raw_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : 16'h0000;

endmodule

@@ rtl/mbrir_packer.sv @@
// Packs frame bytes into 8-byte words and holds the word in an output register.
// Uses mbrir_pkg for beat_t and rsp_item_t.
module mbrir_packer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 beat_valid,
    input  mbrir_pkg::beat_t     beat,
    output logic                 beat_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output mbrir_pkg::rsp_item_t rsp
);
    import mbrir_pkg::*;

    logic [63:0] acc_data_reg;
    logic [3:0]  acc_cnt_reg;
    logic        acc_last_reg;
    logic        acc_exc_reg;
    logic        out_valid_reg;
    rsp_item_t   out_reg;
    logic        full;
    logic        take;
    logic        move;
    logic        beat_fire;

    // word is complete when eight lanes are filled or the frame's last byte is in
    assign full       = acc_cnt_reg[3] | acc_last_reg;
    assign take       = out_valid_reg & ~rsp_stall;
    assign move       = full & (~out_valid_reg | take);
    assign beat_ready = ~full;
    assign beat_fire  = beat_valid & beat_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_data_reg  <= '0;
            acc_cnt_reg   <= '0;
            acc_last_reg  <= 1'b0;
            acc_exc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (move)
            begin
                acc_data_reg  <= '0;
                acc_cnt_reg   <= '0;
                acc_last_reg  <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (take)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (beat_fire)
                begin
                    acc_data_reg[acc_cnt_reg[2:0]*8 +: 8] <= beat.data;
                    acc_cnt_reg  <= acc_cnt_reg + 4'd1;
                    acc_last_reg <= beat.last;
                    acc_exc_reg  <= beat.exc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg.data_word    <= acc_data_reg;
            out_reg.bytes_valid  <= acc_cnt_reg;
            out_reg.is_exception <= acc_exc_reg;
            out_reg.last         <= acc_last_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

@@ rtl/modbus_read_input_registers_slave.sv @@
// Function 04 responder. A load or a broadcast request is taken without stalling the input.
// Any other request stalls the input until the last byte of its response frame has gone to
// the packer: three header bytes, then one store read and two frame bytes per register, one
// byte per cycle in the byte states while the packer is ready, then two CRC bytes (an exception
// frame has no register bytes). Each full 8-byte word before the last and any output stall hold the byte flow.
// rst_n is asynchronous: store reads as zero, slave address 1, 256 registers in use, output empty.
module modbus_read_input_registers_slave (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  mbrir_pkg::req_item_t req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output mbrir_pkg::rsp_item_t rsp,
    input  logic                 wr_en,
    input  logic                 wr_index,
    input  logic [8:0]           wr_data
);
    import mbrir_pkg::*;

    state_t                  state_reg;
    state_t                  state_next;
    logic [7:0]              slave_addr_reg;
    logic [LIMIT_W-1:0]      in_use_reg;
    logic [15:0]             crc_reg;
    logic                    exc_reg;
    logic [7:0]              hdr1_reg;
    logic [7:0]              hdr2_reg;
    logic [REG_AW-1:0]       ptr_reg;
    logic [6:0]              remain_reg;

    logic                    req_fire;
    logic                    start;
    logic                    len_bad;
    logic                    cnt_bad;
    logic                    range_bad;
    logic [LIMIT_W-1:0]      limit;
    logic [16:0]             end_reg_num;
    logic                    beat_valid;
    logic                    beat_ready;
    logic                    beat_fire;
    beat_t                   beat;
    logic                    rd_en;
    logic [15:0]             rd_data;
    logic                    st_wr;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid & ~req_stall;
    assign start     = req_fire & (req.command == CMD_REQUEST) & (req.frame_address != 8'h00);
    assign st_wr     = req_fire & (req.command == CMD_LOAD);

    assign limit       = (in_use_reg > LIMIT_W'(REG_DEPTH)) ? LIMIT_W'(REG_DEPTH) : in_use_reg;
    assign end_reg_num = {1'b0, req.first_register} + {1'b0, req.register_count};
    assign len_bad     = (req.frame_length != FRAME_LEN);
    assign cnt_bad     = (req.register_count == 16'd0) || (req.register_count > 16'(MAX_READ));
    assign range_bad   = ({1'b0, req.first_register} >= {{(17-LIMIT_W){1'b0}}, limit})
                         || (end_reg_num > {{(17-LIMIT_W){1'b0}}, limit});

    assign beat_fire = beat_valid & beat_ready;

    mbrir_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (st_wr),
        .wr_addr (req.load_index[REG_AW-1:0]),
        .wr_data (req.load_value),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    mbrir_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_ready (beat_ready),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_HDR0;
            S_HDR0:  if (beat_fire) state_next = S_HDR1;
            S_HDR1:  if (beat_fire) state_next = S_HDR2;
            S_HDR2:  if (beat_fire) state_next = exc_reg ? S_CRCLO : S_RD;
            S_RD:    state_next = S_VHI;
            S_VHI:   if (beat_fire) state_next = S_VLO;
            S_VLO:   if (beat_fire) state_next = (remain_reg == 7'd1) ? S_CRCLO : S_RD;
            S_CRCLO: if (beat_fire) state_next = S_CRCHI;
            S_CRCHI: if (beat_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        beat_valid = 1'b0;
        beat.data  = 8'h00;
        beat.last  = 1'b0;
        beat.exc   = exc_reg;
        rd_en      = 1'b0;
        unique case (state_reg)
            S_IDLE:  ;
            S_HDR0:
            begin
                beat_valid = 1'b1;
                beat.data  = slave_addr_reg;
            end
            S_HDR1:
            begin
                beat_valid = 1'b1;
                beat.data  = hdr1_reg;
            end
            S_HDR2:
            begin
                beat_valid = 1'b1;
                beat.data  = hdr2_reg;
            end
            S_RD:    rd_en = 1'b1;
            S_VHI:
            begin
                beat_valid = 1'b1;
                beat.data  = rd_data[15:8];
            end
            S_VLO:
            begin
                beat_valid = 1'b1;
                beat.data  = rd_data[7:0];
            end
            S_CRCLO:
            begin
                beat_valid = 1'b1;
                beat.data  = crc_reg[7:0];
            end
            S_CRCHI:
            begin
                beat_valid = 1'b1;
                beat.data  = crc_reg[15:8];
                beat.last  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slave_addr_reg <= 8'd1;
            in_use_reg     <= LIMIT_W'(REG_DEPTH);
            crc_reg        <= CRC_INIT;
            exc_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_SLAVE_ADDRESS:    slave_addr_reg <= wr_data[7:0];
                    CFG_REGISTERS_IN_USE: in_use_reg     <= wr_data;
                    default: ;
                endcase
            end
            if (start)
            begin
                crc_reg <= CRC_INIT;
                exc_reg <= len_bad | cnt_bad | range_bad;
            end
            else if (beat_fire && state_reg != S_CRCLO && state_reg != S_CRCHI)
            begin
                crc_reg <= crc_byte(crc_reg, beat.data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ptr_reg    <= req.first_register[REG_AW-1:0];
            remain_reg <= req.register_count[6:0];
            if (len_bad || cnt_bad)
            begin
                hdr1_reg <= EXC_FUNCTION;
                hdr2_reg <= EXC_BAD_VALUE;
            end
            else if (range_bad)
            begin
                hdr1_reg <= EXC_FUNCTION;
                hdr2_reg <= EXC_BAD_ADDR;
            end
            else
            begin
                hdr1_reg <= req.function_code;
                hdr2_reg <= {req.register_count[6:0], 1'b0};
            end
        end
        else if (state_reg == S_VLO && beat_fire)
        begin
            ptr_reg    <= ptr_reg + REG_AW'(1);
            remain_reg <= remain_reg - 7'd1;
        end
    end

endmodule
